@@ sv/text_console_cursor_defines.svh @@
// assertion macros used by the text console cursor datapath
`ifndef TEXT_CONSOLE_CURSOR_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// check on every rising clock edge outside reset
`define TCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also applies while reset is held
`define TCC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCC_ASSERT(lbl, prop, msg)
`define TCC_ASSERT_RST(lbl, prop, msg)
`endif

`endif

@@ sv/tcc_pkg.sv @@
// types and constants shared by the text console cursor modules
package tcc_pkg;

  localparam int CHAR_W  = 8;
  localparam int COL_W   = 6;
  localparam int ROW_W   = 5;
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int COLS_REG_W = 7;
  localparam int ROWS_REG_W = 6;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [KIND_W-1:0] KIND_DRAW   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SCROLL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ROWS    = 2'd1;

  localparam logic [COLS_REG_W-1:0] COLS_RESET = 7'd30;
  localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 6'd8;
  localparam logic [COLS_REG_W-1:0] COLS_MAX   = 7'd64;
  localparam logic [ROWS_REG_W-1:0] ROWS_MAX   = 6'd32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DRAW,
    S_LF,
    S_SCROLL,
    S_REPORT
  } state_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_DRAW,
    EMIT_SCROLL,
    EMIT_REPORT
  } emit_t;

  // controller to datapath
  typedef struct packed {
    logic  latch;
    emit_t emit;
    logic  step_right;
    logic  line_feed;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_is_tab;
    logic in_is_lf;
    logic in_is_cr;
    logic is_tab;
    logic adv;
    logic wrap;
    logic at_bottom;
    logic tab_stop;
    logic slot_free;
  } dp_status_t;

endpackage

@@ sv/tcc_ctrl.sv @@
// sequencer that walks one character through draws, scroll and report
module tcc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tcc_pkg::dp_status_t status,
  output tcc_pkg::ctrl_cmd_t  cmd
);
  import tcc_pkg::*;

  state_t state_r, state_nxt;
  logic   do_step;

  // cursor moves after a draw for tabs and for advancing glyphs
  assign do_step = status.is_tab || status.adv;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (status.in_is_lf) begin
            state_nxt = S_LF;
          end else if (status.in_is_cr) begin
            state_nxt = S_REPORT;
          end else begin
            state_nxt = S_DRAW;
          end
        end
      end
      S_DRAW: begin
        if (status.slot_free) begin
          if (!do_step) begin
            state_nxt = S_REPORT;
          end else if (status.wrap && status.at_bottom) begin
            state_nxt = S_SCROLL;
          end else if (status.is_tab && !status.wrap && !status.tab_stop) begin
            state_nxt = S_DRAW;
          end else begin
            state_nxt = S_REPORT;
          end
        end
      end
      S_LF: begin
        state_nxt = status.at_bottom ? S_SCROLL : S_REPORT;
      end
      S_SCROLL: begin
        if (status.slot_free) state_nxt = S_REPORT;
      end
      S_REPORT: begin
        if (status.slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    in_ready       = 1'b0;
    cmd.latch      = 1'b0;
    cmd.emit       = EMIT_NONE;
    cmd.step_right = 1'b0;
    cmd.line_feed  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      S_DRAW: begin
        if (status.slot_free) begin
          cmd.emit       = EMIT_DRAW;
          cmd.step_right = do_step;
        end
      end
      S_LF: begin
        cmd.line_feed = 1'b1;
      end
      S_SCROLL: begin
        if (status.slot_free) cmd.emit = EMIT_SCROLL;
      end
      S_REPORT: begin
        if (status.slot_free) cmd.emit = EMIT_REPORT;
      end
      default: ;
    endcase
  end

endmodule

@@ sv/tcc_datapath.sv @@
// cursor, configuration registers and result register
`include "text_console_cursor_defines.svh"

module tcc_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [tcc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tcc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [tcc_pkg::CHAR_W-1:0]          in_char_code,
  input  logic                                in_advance,
  input  tcc_pkg::ctrl_cmd_t                  cmd,
  output tcc_pkg::dp_status_t                 status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tcc_pkg::KIND_W-1:0]          out_command_kind,
  output logic [tcc_pkg::COL_W-1:0]           out_cell_column,
  output logic [tcc_pkg::ROW_W-1:0]           out_cell_row,
  output logic [tcc_pkg::CHAR_W-1:0]          out_glyph_code,
  output logic                                out_last_of_run
);
  import tcc_pkg::*;

  logic [COLS_REG_W-1:0] cols_r;
  logic [ROWS_REG_W-1:0] rows_r;
  logic [COL_W-1:0]      col_r, col_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic [CHAR_W-1:0]     char_r;
  logic                  adv_r;
  logic                  out_valid_r;
  logic [KIND_W-1:0]     kind_r;
  logic [COL_W-1:0]      ocol_r;
  logic [ROW_W-1:0]      orow_r;
  logic [CHAR_W-1:0]     glyph_r;
  logic                  last_r;

  logic [COLS_REG_W-1:0] eff_cols;
  logic [ROWS_REG_W-1:0] eff_rows;
  logic [ROW_W-1:0]      last_row;
  logic [COLS_REG_W-1:0] col_inc;
  logic                  is_tab;
  logic                  wrap;
  logic                  at_bottom;
  logic                  slot_free;

  // configuration writes, saturated where used
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= COLS_RESET;
      rows_r <= ROWS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TEXT_COLUMNS: cols_r <= cfg_data;
        REG_TEXT_ROWS:    rows_r <= cfg_data[ROWS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cols_r == '0) eff_cols = COLS_REG_W'(1);
    else if (cols_r > COLS_MAX) eff_cols = COLS_MAX;
    else eff_cols = cols_r;
    if (rows_r == '0) eff_rows = ROWS_REG_W'(1);
    else if (rows_r > ROWS_MAX) eff_rows = ROWS_MAX;
    else eff_rows = rows_r;
  end

  assign last_row  = ROW_W'(eff_rows - ROWS_REG_W'(1));
  assign col_inc   = {1'b0, col_r} + COLS_REG_W'(1);
  assign wrap      = col_inc >= eff_cols;
  assign at_bottom = row_r >= last_row;
  assign is_tab    = char_r == CH_TAB;
  assign slot_free = !out_valid_r || out_ready;

  // status towards the controller
  always_comb begin
    status.in_is_tab = in_char_code == CH_TAB;
    status.in_is_lf  = in_char_code == CH_LF;
    status.in_is_cr  = in_char_code == CH_CR;
    status.is_tab    = is_tab;
    status.adv       = adv_r;
    status.wrap      = wrap;
    status.at_bottom = at_bottom;
    status.tab_stop  = col_inc[1:0] == 2'b00;
    status.slot_free = slot_free;
  end

  // captured item
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      char_r <= in_char_code;
      adv_r  <= in_advance;
    end
  end

  // cursor movement: step right wraps into a line feed
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.line_feed || (cmd.step_right && wrap)) begin
      col_nxt = '0;
      row_nxt = at_bottom ? last_row : row_r + ROW_W'(1);
    end else if (cmd.step_right) begin
      col_nxt = col_inc[COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit != EMIT_NONE) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    unique case (cmd.emit)
      EMIT_DRAW: begin
        kind_r  <= KIND_DRAW;
        ocol_r  <= col_r;
        orow_r  <= row_r;
        glyph_r <= is_tab ? CH_SPACE : char_r;
        last_r  <= 1'b0;
      end
      EMIT_SCROLL: begin
        kind_r  <= KIND_SCROLL;
        ocol_r  <= '0;
        orow_r  <= '0;
        glyph_r <= '0;
        last_r  <= 1'b0;
      end
      EMIT_REPORT: begin
        kind_r  <= KIND_REPORT;
        ocol_r  <= col_r;
        orow_r  <= row_r;
        glyph_r <= '0;
        last_r  <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_command_kind = kind_r;
  assign out_cell_column  = ocol_r;
  assign out_cell_row     = orow_r;
  assign out_glyph_code   = glyph_r;
  assign out_last_of_run  = last_r;

  // a new result never overwrites one that is still waiting
  `TCC_ASSERT(a_emit_into_free_slot, (cmd.emit != EMIT_NONE) |-> slot_free, "result overwritten")
  // only the cursor report closes a run
  `TCC_ASSERT(a_last_is_report, (out_valid_r && last_r) |-> (kind_r == KIND_REPORT), "bad last")
  // reset returns the cursor home
  `TCC_ASSERT_RST(a_reset_home, !rst_n |=> (col_r == '0 && row_r == '0), "cursor not home")

endmodule

@@ sv/text_console_cursor.sv @@
// text console cursor: character in, draw, scroll and report commands out
// a glyph gives a draw and a tab up to four draws, each then a scroll if it wraps on the bottom row,
// and the report; a carriage return gives only the report, a line feed a scroll on the bottom row
// and the report; one result loaded per cycle while the output is not stalled
// the next item is accepted in the cycle after the report is loaded
// synchronous active-low reset: cursor at column 0 row 0, 30 columns, 8 rows, no result
module text_console_cursor (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tcc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [tcc_pkg::CHAR_W-1:0]     in_char_code,
  input  logic                           in_advance,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tcc_pkg::KIND_W-1:0]     out_command_kind,
  output logic [tcc_pkg::COL_W-1:0]      out_cell_column,
  output logic [tcc_pkg::ROW_W-1:0]      out_cell_row,
  output logic [tcc_pkg::CHAR_W-1:0]     out_glyph_code,
  output logic                           out_last_of_run
);
  import tcc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  tcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tcc_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_char_code     (in_char_code),
    .in_advance       (in_advance),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_command_kind (out_command_kind),
    .out_cell_column  (out_cell_column),
    .out_cell_row     (out_cell_row),
    .out_glyph_code   (out_glyph_code),
    .out_last_of_run  (out_last_of_run)
  );

endmodule

@@ tb/tb.sv @@
// testbench for the text console cursor: directed and random characters against a cursor model
`timescale 1ns / 1ps

module tb;
  import tcc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int SETTLE_CYCLES   = 8;

  typedef struct packed {
    logic [KIND_W-1:0] command_kind;
    logic [COL_W-1:0]  cell_column;
    logic [ROW_W-1:0]  cell_row;
    logic [CHAR_W-1:0] glyph_code;
    logic              last_of_run;
  } console_cmd_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CHAR_W-1:0]     in_char_code = '0;
  logic                  in_advance = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [KIND_W-1:0]     out_command_kind;
  logic [COL_W-1:0]      out_cell_column;
  logic [ROW_W-1:0]      out_cell_row;
  logic [CHAR_W-1:0]     out_glyph_code;
  logic                  out_last_of_run;

  // cursor model state and the commands it still expects
  console_cmd_t          pending_commands[$];
  logic [COLS_REG_W-1:0] model_columns;
  logic [ROWS_REG_W-1:0] model_rows;
  logic [COL_W-1:0]      cur_col;
  logic [ROW_W-1:0]      cur_row;

  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_off_pending = 1'b0;
  int mismatches = 0;
  int chars_accepted = 0;
  int commands_checked = 0;
  int scrolls_seen = 0;

  text_console_cursor uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_code     (in_char_code),
    .in_advance       (in_advance),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_command_kind (out_command_kind),
    .out_cell_column  (out_cell_column),
    .out_cell_row     (out_cell_row),
    .out_glyph_code   (out_glyph_code),
    .out_last_of_run  (out_last_of_run)
  );

  always #1 clk = ~clk;

  // effective geometry, saturated to the legal range
  function automatic int line_width();
    if (model_columns < 1) return 1;
    if (model_columns > 64) return 64;
    return int'(model_columns);
  endfunction

  function automatic int screen_height();
    if (model_rows < 1) return 1;
    if (model_rows > 32) return 32;
    return int'(model_rows);
  endfunction

  function automatic void queue_command(logic [KIND_W-1:0] kind, logic [COL_W-1:0] col,
                                        logic [ROW_W-1:0] row, logic [CHAR_W-1:0] glyph,
                                        logic last);
    console_cmd_t c;
    c.command_kind = kind;
    c.cell_column  = col;
    c.cell_row     = row;
    c.glyph_code   = glyph;
    c.last_of_run  = last;
    pending_commands.push_back(c);
  endfunction

  // next row, or a scroll on (or below) the bottom row
  function automatic void new_line();
    int bottom;
    bottom = screen_height() - 1;
    if (int'(cur_row) < bottom) begin
      cur_row = cur_row + ROW_W'(1);
    end else begin
      queue_command(KIND_SCROLL, '0, '0, '0, 1'b0);
      cur_row = bottom[ROW_W-1:0];
    end
    cur_col = '0;
  endfunction

  // one column right, wrapping when the line is full or already overrun
  function automatic void cursor_right();
    int nxt;
    nxt = int'(cur_col) + 1;
    if (nxt >= line_width()) new_line();
    else cur_col = nxt[COL_W-1:0];
  endfunction

  function automatic void predict_commands(logic [CHAR_W-1:0] ch, logic adv);
    case (ch)
      CH_TAB: begin
        for (int i = 0; i < 4; i++) begin
          queue_command(KIND_DRAW, cur_col, cur_row, CH_SPACE, 1'b0);
          cursor_right();
          if (cur_col[1:0] == 2'b00) break;
        end
      end
      CH_LF: new_line();
      CH_CR: ;
      default: begin
        queue_command(KIND_DRAW, cur_col, cur_row, ch, 1'b0);
        if (adv) cursor_right();
      end
    endcase
    queue_command(KIND_REPORT, cur_col, cur_row, '0, 1'b1);
  endfunction

  // model follows every accepted item and register write
  always @(posedge clk) begin
    if (!rst_n) begin
      model_columns = COLS_RESET;
      model_rows    = ROWS_RESET;
      cur_col       = '0;
      cur_row       = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TEXT_COLUMNS) model_columns = cfg_data;
        else if (cfg_index == REG_TEXT_ROWS) model_rows = cfg_data[ROWS_REG_W-1:0];
      end
      if (in_valid && in_ready) begin
        predict_commands(in_char_code, in_advance);
        chars_accepted++;
      end
    end
  end

  function automatic void check_field(string field, int want, int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  // compare each command against the oldest expectation
  always @(posedge clk) begin : result_check
    console_cmd_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_commands.size() == 0) begin
        mismatches++;
        $display("%0t: expected no command, got kind %0d col %0d row %0d glyph %0d last %0b",
                 $time, out_command_kind, out_cell_column, out_cell_row, out_glyph_code,
                 out_last_of_run);
      end else begin
        want = pending_commands.pop_front();
        check_field("command_kind", int'(want.command_kind), int'(out_command_kind));
        check_field("cell_column", int'(want.cell_column), int'(out_cell_column));
        check_field("cell_row", int'(want.cell_row), int'(out_cell_row));
        check_field("glyph_code", int'(want.glyph_code), int'(out_glyph_code));
        check_field("last_of_run", int'(want.last_of_run), int'(out_last_of_run));
        commands_checked++;
        if (want.command_kind == KIND_SCROLL) scrolls_seen++;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        for (int k = 0; k < HOLD_OFF_CYCLES; k++) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // offer one item, with random idle cycles ahead of it
  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic adv);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= ch;
    in_advance   <= adv;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_char();
    int pick;
    logic [CHAR_W-1:0] ch;
    pick = $urandom_range(99);
    if (pick < 22) ch = CH_TAB;
    else if (pick < 38) ch = CH_LF;
    else if (pick < 42) ch = CH_CR;
    else ch = CHAR_W'($urandom_range(255));
    send_char(ch, 1'($urandom_range(1)));
  endtask

  // stop sending and wait until every expected command has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_commands.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] cols, input logic [CFG_DATA_W-1:0] rows);
    write_reg(REG_TEXT_COLUMNS, cols);
    write_reg(REG_TEXT_ROWS, rows);
    cfg_valid <= 1'b0;
  endtask

  // glyph codes at the extremes, with and without advance, and carriage return
  task automatic test_glyph_extremes();
    send_char(8'h00, 1'b1);
    send_char(8'hff, 1'b1);
    send_char(8'h41, 1'b0);
    send_char(CH_CR, 1'b1);
    send_char(CH_CR, 1'b0);
    send_char(8'h1f, 1'b1);
    send_char(8'h80, 1'b0);
  endtask

  // tab from just short of a stop and from on a stop
  task automatic test_tab_stops();
    send_char(CH_TAB, 1'b0);
    send_char(CH_TAB, 1'b1);
    drain();
  endtask

  // small screen: line feeds into a scroll, tab and glyph wrapping on the bottom row
  task automatic test_scroll_at_bottom();
    configure(7'd4, 7'd2);
    send_char(CH_LF, 1'b0);
    send_char(CH_LF, 1'b1);
    send_char(CH_TAB, 1'b0);
    repeat (4) send_char(8'h5a, 1'b1);
    drain();
  endtask

  // oversized register values, then a shrink that leaves the cursor off the screen
  task automatic test_shrunk_geometry();
    write_reg(REG_TEXT_COLUMNS, 7'h7f);
    write_reg(REG_TEXT_ROWS, 7'h7f);
    write_reg(REG_UNUSED_2, 7'h55);
    write_reg(REG_UNUSED_3, 7'h2a);
    cfg_valid <= 1'b0;
    send_char(CH_TAB, 1'b0);
    send_char(CH_TAB, 1'b0);
    send_char(CH_LF, 1'b0);
    send_char(CH_TAB, 1'b1);
    send_char(CH_TAB, 1'b1);
    drain();
    configure(7'd0, 7'd0);
    send_char(8'h2a, 1'b0);
    send_char(CH_TAB, 1'b0);
    send_char(8'h2b, 1'b1);
    send_char(CH_LF, 1'b0);
    drain();
  endtask

  task automatic run_phase(input int n_items, input int idle_pct, input int stall);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    repeat (n_items) send_random_char();
    drain();
  endtask

  task automatic random_geometry();
    logic [CFG_DATA_W-1:0] cols;
    logic [CFG_DATA_W-1:0] rows;
    cols = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom_range(127))
                                    : CFG_DATA_W'($urandom_range(12, 1));
    rows = ($urandom_range(3) == 0) ? CFG_DATA_W'($urandom_range(127))
                                    : CFG_DATA_W'($urandom_range(6, 1));
    configure(cols, rows);
  endtask

  // random characters under each mix of sender idling and receiver stalls
  task automatic test_random_traffic();
    configure(COLS_MAX, CFG_DATA_W'(ROWS_MAX));
    run_phase(59, 0, 0);
    random_geometry();
    run_phase(59, 47, 0);
    random_geometry();
    run_phase(59, 0, 47);
    random_geometry();
    run_phase(59, 19, 19);
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_output_backpressure();
    random_geometry();
    send_idle_pct = 0;
    stall_pct     = 0;
    @(negedge clk);
    hold_off_pending = 1'b1;
    @(posedge clk);
    repeat (24) send_random_char();
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_glyph_extremes();
    test_tab_stops();
    test_scroll_at_bottom();
    test_shrunk_geometry();
    test_random_traffic();
    test_output_backpressure();
    $display("covered %0d characters and %0d commands (%0d scrolls) across idle and stall mixes",
             chars_accepted, commands_checked, scrolls_seen);
    $display("geometry from a single cell up to 64 x 32, with a %0d cycle output hold-off",
             HOLD_OFF_CYCLES);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1_000_000;
    $display("timeout with %0d commands outstanding", pending_commands.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+sv
sv/tcc_pkg.sv
sv/tcc_ctrl.sv
sv/tcc_datapath.sv
sv/text_console_cursor.sv
tb/tb.sv
